// ----- rtl/hptw_pkg.sv -----
// ----------------------------------------------------------------------------
// hptw_pkg
// Default geometry for the hierarchical page table walker.
// ----------------------------------------------------------------------------
package hptw_pkg;

  localparam int DEF_OFFSET_BITS = 4;
  localparam int DEF_VADDR_BITS  = 20;
  localparam int DEF_LEVELS      = 4;
  localparam int DEF_FRAME_COUNT = 64;
  localparam int DEF_WORD_BITS   = 32;

  // width of the virtual_address port
  localparam int VA_PORT_BITS = 24;

endpackage

// ----- rtl/hptw_ram.sv -----
// ----------------------------------------------------------------------------
// hptw_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module hptw_ram #(
  parameter int AW    = 10,
  parameter int DW    = 32,
  parameter int DEPTH = 1024
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/hierarchical_page_table_walker.sv -----
// ----------------------------------------------------------------------------
// hierarchical_page_table_walker
// One word read or write per transaction through a multilevel page table
// kept in physical frames, with demand paging to a swap store.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         kind, virtual_address, write_data
//  result    done (1-cycle pulse) status, read_data
//
//  A hit reads one table entry per level, then makes the access.
//  A missing entry adds a table scan, a victim scan if no frame is free,
//  and each page copy; all on the one read port of the physical memory.
//  Reset starts a clearing pass over all 2^(page bits + OFFSET_BITS)
//  words (2^20 at defaults) of the swap store and over the root frame,
//  busy high.
//  Results cannot be stalled; done pulses for one cycle.
// ----------------------------------------------------------------------------
module hierarchical_page_table_walker
  import hptw_pkg::*;
#(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int VADDR_BITS  = DEF_VADDR_BITS,
  parameter int LEVELS      = DEF_LEVELS,
  parameter int FRAME_COUNT = DEF_FRAME_COUNT,
  parameter int WORD_BITS   = DEF_WORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    kind,
  input  logic [VA_PORT_BITS-1:0] virtual_address,
  input  logic signed [31:0]      write_data,
  output logic                    done,
  output logic                    status,
  output logic signed [31:0]      read_data
);

  localparam int OB         = OFFSET_BITS;
  localparam int PAGE_WORDS = 1 << OB;
  localparam int PATH_W     = LEVELS * OB;
  localparam int VPN_RAW    = (VADDR_BITS > OB) ? VADDR_BITS - OB : 0;
  localparam int VPN_BITS   = (VPN_RAW < PATH_W) ? VPN_RAW : PATH_W;
  localparam int VPN_W      = (VPN_BITS > 0) ? VPN_BITS : 1;
  localparam int FRAME_W    = $clog2(FRAME_COUNT);
  localparam int PHYS_AW    = FRAME_W + OB;
  localparam int PHYS_DEPTH = FRAME_COUNT * PAGE_WORDS;
  localparam int SWAP_AW    = VPN_BITS + OB;
  localparam int SWAP_DEPTH = 1 << SWAP_AW;
  localparam int D_W        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SLOT_W     = OB + 1;
  localparam int VA_EXT_W   = (VA_PORT_BITS > PATH_W + OB) ? VA_PORT_BITS : PATH_W + OB;

  localparam logic [D_W-1:0]     LAST_D    = D_W'(LEVELS - 1);
  localparam logic [VPN_W-1:0]   VPN_MASK  = (VPN_BITS == 0) ? {VPN_W{1'b0}} : {VPN_W{1'b1}};
  localparam logic [FRAME_W:0]   FRAME_LIM = (FRAME_W + 1)'(FRAME_COUNT);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_WALK_RD  = 4'd2;
  localparam logic [3:0] S_WALK_CHK = 4'd3;
  localparam logic [3:0] S_ES_STEP  = 4'd4;
  localparam logic [3:0] S_ES_CHK   = 4'd5;
  localparam logic [3:0] S_RULE2    = 4'd6;
  localparam logic [3:0] S_VS_STEP  = 4'd7;
  localparam logic [3:0] S_VS_CHK   = 4'd8;
  localparam logic [3:0] S_VS_DIST  = 4'd9;
  localparam logic [3:0] S_VS_END   = 4'd10;
  localparam logic [3:0] S_EVICT    = 4'd11;
  localparam logic [3:0] S_FILL     = 4'd12;
  localparam logic [3:0] S_LINK     = 4'd13;
  localparam logic [3:0] S_ACC      = 4'd14;
  localparam logic [3:0] S_ACC_OUT  = 4'd15;

  logic [3:0]          state;
  logic [SWAP_AW-1:0]  clr_cnt;
  logic [D_W-1:0]      level;
  logic [D_W-1:0]      d;
  logic [FRAME_W-1:0]  cur;
  logic [FRAME_W-1:0]  nf;
  logic [FRAME_W-1:0]  top;
  logic [PATH_W-1:0]   path;
  logic [VPN_W-1:0]    vpn_r;
  logic [OB-1:0]       off_r;
  logic                kind_r;
  logic [WORD_BITS-1:0] wdata_r;
  logic [SLOT_W-1:0]   j;

  // depth-first scan stack
  logic [FRAME_W-1:0]  sf  [LEVELS];
  logic [SLOT_W-1:0]   ss  [LEVELS];
  logic                se  [LEVELS];
  logic [FRAME_W-1:0]  pf  [LEVELS];
  logic [OB-1:0]       ps  [LEVELS];
  logic [PATH_W-1:0]   pre [LEVELS];

  // victim candidate and best so far
  logic [VPN_W-1:0]    cand_page;
  logic [FRAME_W-1:0]  cand_f;
  logic [FRAME_W-1:0]  cand_par;
  logic [OB-1:0]       cand_slot;
  logic [VPN_W-1:0]    xdiff;
  logic                vfound;
  logic [VPN_W-1:0]    vdist;
  logic [VPN_W-1:0]    vpage;
  logic [FRAME_W-1:0]  vf;
  logic [FRAME_W-1:0]  vpar;
  logic [OB-1:0]       vslot;

  logic                 phys_we;
  logic [PHYS_AW-1:0]   phys_waddr;
  logic [WORD_BITS-1:0] phys_wdata;
  logic [PHYS_AW-1:0]   phys_raddr;
  logic [WORD_BITS-1:0] phys_rdata;
  logic                 swap_we;
  logic [SWAP_AW-1:0]   swap_waddr;
  logic [WORD_BITS-1:0] swap_wdata;
  logic [SWAP_AW-1:0]   swap_raddr;
  logic [WORD_BITS-1:0] swap_rdata;

  logic [VA_EXT_W-1:0]       va_ext;
  logic [OB-1:0]             idx;
  logic [OB-1:0]             jm1;
  logic                      leaf_lvl;
  logic                      es_found;
  logic                      rd_nz;
  logic [FRAME_W-1:0]        rd_frame;
  logic [PATH_W+OB-1:0]      page_cat;
  logic [VPN_W-1:0]          page_v;
  logic [VPN_W-1:0]          neg_x;
  logic [VPN_W-1:0]          cyc_dist;
  logic signed [63:0]        wext;
  logic signed [WORD_BITS-1:0] rword;
  logic signed [63:0]        rext;
  logic [VPN_W+OB-1:0]       evict_addr;
  logic [VPN_W+OB-1:0]       load_addr;

  hptw_ram #(.AW(PHYS_AW), .DW(WORD_BITS), .DEPTH(PHYS_DEPTH)) u_phys (
    .clk   (clk),
    .we    (phys_we),
    .waddr (phys_waddr),
    .wdata (phys_wdata),
    .raddr (phys_raddr),
    .rdata (phys_rdata)
  );

  hptw_ram #(.AW(SWAP_AW), .DW(WORD_BITS), .DEPTH(SWAP_DEPTH)) u_swap (
    .clk   (clk),
    .we    (swap_we),
    .waddr (swap_waddr),
    .wdata (swap_wdata),
    .raddr (swap_raddr),
    .rdata (swap_rdata)
  );

  assign busy       = (state != S_IDLE);
  assign va_ext     = VA_EXT_W'(virtual_address);
  assign idx        = path[PATH_W-1 -: OB];
  assign jm1        = OB'(j - 1'b1);
  assign leaf_lvl   = (level == LAST_D);
  assign es_found   = se[d] && (sf[d] != '0) && (sf[d] != cur);
  assign rd_nz      = (phys_rdata != '0);
  assign rd_frame   = phys_rdata[FRAME_W-1:0];
  assign page_cat   = {pre[d], ss[d][OB-1:0]};
  assign page_v     = page_cat[VPN_W-1:0] & VPN_MASK;
  assign neg_x      = (VPN_W'(0) - xdiff) & VPN_MASK;
  assign cyc_dist   = (xdiff < neg_x) ? xdiff : neg_x;
  assign wext       = 64'(write_data);
  assign rword      = phys_rdata;
  assign rext       = 64'(rword);
  assign evict_addr = {vpage, jm1};
  assign load_addr  = {vpn_r, j[OB-1:0]};

  // memory port control
  always_comb begin
    phys_we    = 1'b0;
    phys_waddr = {cur, idx};
    phys_wdata = '0;
    phys_raddr = {cur, idx};
    swap_we    = 1'b0;
    swap_waddr = clr_cnt;
    swap_wdata = '0;
    swap_raddr = load_addr[SWAP_AW-1:0];
    unique case (state)
      S_CLEAR: begin
        swap_we    = 1'b1;
        phys_we    = ((clr_cnt >> OB) == '0);
        phys_waddr = {FRAME_W'(0), clr_cnt[OB-1:0]};
      end
      S_ES_STEP: begin
        if (ss[d][OB]) begin
          phys_we    = es_found;
          phys_waddr = {pf[d], ps[d]};
        end else begin
          phys_raddr = {sf[d], ss[d][OB-1:0]};
        end
      end
      S_VS_STEP: begin
        phys_raddr = {sf[d], ss[d][OB-1:0]};
      end
      S_VS_END: begin
        phys_we    = vfound;
        phys_waddr = {vpar, vslot};
      end
      S_EVICT: begin
        phys_raddr = {nf, j[OB-1:0]};
        swap_we    = (j != '0);
        swap_waddr = evict_addr[SWAP_AW-1:0];
        swap_wdata = phys_rdata;
      end
      S_FILL: begin
        if (!leaf_lvl) begin
          phys_we    = !j[OB];
          phys_waddr = {nf, j[OB-1:0]};
        end else begin
          phys_we    = (j != '0);
          phys_waddr = {nf, jm1};
          phys_wdata = swap_rdata;
        end
      end
      S_LINK: begin
        phys_we    = 1'b1;
        phys_wdata = WORD_BITS'(nf);
      end
      S_ACC: begin
        phys_we    = kind_r;
        phys_waddr = {cur, off_r};
        phys_wdata = wdata_r;
        phys_raddr = {cur, off_r};
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
      status  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            kind_r  <= kind;
            off_r   <= virtual_address[OB-1:0];
            wdata_r <= wext[WORD_BITS-1:0];
            path    <= va_ext[OB +: PATH_W];
            vpn_r   <= va_ext[OB +: VPN_W] & VPN_MASK;
            cur     <= '0;
            level   <= '0;
            if ((virtual_address >> VADDR_BITS) != '0) begin
              done      <= 1'b1;
              status    <= 1'b1;
              read_data <= '0;
            end else begin
              state <= S_WALK_RD;
            end
          end
        end
        S_WALK_RD: begin
          state <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (rd_nz) begin
            cur <= rd_frame;
            if (leaf_lvl) begin
              state <= S_ACC;
            end else begin
              level <= level + 1'b1;
              path  <= path << OB;
              state <= S_WALK_RD;
            end
          end else begin
            d     <= '0;
            sf[0] <= '0;
            ss[0] <= '0;
            se[0] <= 1'b1;
            top   <= '0;
            state <= S_ES_STEP;
          end
        end
        S_ES_STEP: begin
          if (ss[d][OB]) begin
            if (es_found) begin
              // parent entry cleared by the port logic this cycle
              nf    <= sf[d];
              j     <= '0;
              state <= S_FILL;
            end else if (d == '0) begin
              state <= S_RULE2;
            end else begin
              d <= d - 1'b1;
            end
          end else begin
            state <= S_ES_CHK;
          end
        end
        S_ES_CHK: begin
          ss[d] <= ss[d] + 1'b1;
          if (rd_nz) begin
            se[d] <= 1'b0;
            if (rd_frame > top) begin
              top <= rd_frame;
            end
            if (d != LAST_D) begin
              sf[d + 1'b1] <= rd_frame;
              ss[d + 1'b1] <= '0;
              se[d + 1'b1] <= 1'b1;
              pf[d + 1'b1] <= sf[d];
              ps[d + 1'b1] <= ss[d][OB-1:0];
              d            <= d + 1'b1;
            end
          end
          state <= S_ES_STEP;
        end
        S_RULE2: begin
          if (({1'b0, top} + 1'b1) < FRAME_LIM) begin
            nf    <= top + 1'b1;
            j     <= '0;
            state <= S_FILL;
          end else begin
            d      <= '0;
            sf[0]  <= '0;
            ss[0]  <= '0;
            pre[0] <= '0;
            vfound <= 1'b0;
            vdist  <= '0;
            state  <= S_VS_STEP;
          end
        end
        S_VS_STEP: begin
          if (ss[d][OB]) begin
            if (d == '0) begin
              state <= S_VS_END;
            end else begin
              d <= d - 1'b1;
            end
          end else begin
            state <= S_VS_CHK;
          end
        end
        S_VS_CHK: begin
          ss[d] <= ss[d] + 1'b1;
          state <= S_VS_STEP;
          if (rd_nz) begin
            if (d != LAST_D) begin
              sf[d + 1'b1]  <= rd_frame;
              ss[d + 1'b1]  <= '0;
              pre[d + 1'b1] <= page_cat[PATH_W-1:0];
              d             <= d + 1'b1;
            end else begin
              cand_page <= page_v;
              cand_f    <= rd_frame;
              cand_par  <= sf[d];
              cand_slot <= ss[d][OB-1:0];
              xdiff     <= (vpn_r - page_v) & VPN_MASK;
              state     <= S_VS_DIST;
            end
          end
        end
        S_VS_DIST: begin
          // strict compare keeps the first leaf in scan order on a tie
          if (cyc_dist > vdist) begin
            vfound <= 1'b1;
            vdist  <= cyc_dist;
            vpage  <= cand_page;
            vf     <= cand_f;
            vpar   <= cand_par;
            vslot  <= cand_slot;
          end
          state <= S_VS_STEP;
        end
        S_VS_END: begin
          if (!vfound) begin
            done      <= 1'b1;
            status    <= 1'b1;
            read_data <= '0;
            state     <= S_IDLE;
          end else begin
            nf    <= vf;
            j     <= '0;
            state <= S_EVICT;
          end
        end
        S_EVICT: begin
          if (j[OB]) begin
            j     <= '0;
            state <= S_FILL;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_FILL: begin
          if (j[OB]) begin
            state <= S_LINK;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_LINK: begin
          cur <= nf;
          if (leaf_lvl) begin
            state <= S_ACC;
          end else begin
            level <= level + 1'b1;
            path  <= path << OB;
            state <= S_WALK_RD;
          end
        end
        S_ACC: begin
          if (kind_r) begin
            done      <= 1'b1;
            status    <= 1'b0;
            read_data <= '0;
            state     <= S_IDLE;
          end else begin
            state <= S_ACC_OUT;
          end
        end
        S_ACC_OUT: begin
          done      <= 1'b1;
          status    <= 1'b0;
          read_data <= rext[31:0];
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result only ever lands as the sequencer returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe outside idle");

  // failed transactions return zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (read_data == '0))
    else $error("nonzero data on failed transaction");

  // an accepted transaction either completes at once or holds busy
  a_accept_prog: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted transaction dropped");

endmodule

// ----- sim/hptw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptw_checker
// Watches the request and result channels of the page table walker, keeps
// its own copy of physical memory and swap, predicts each result and
// compares it with what the walker returns.
// ----------------------------------------------------------------------------
module hptw_checker
  import hptw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    kind,
  input  logic [VA_PORT_BITS-1:0] virtual_address,
  input  logic signed [31:0]      write_data,
  input  logic                    done,
  input  logic                    status,
  input  logic signed [31:0]      read_data,
  output int                      errors,
  output int                      pending
);

  localparam int PAGE_WORDS = 1 << DEF_OFFSET_BITS;
  localparam int VPN_BITS   = DEF_VADDR_BITS - DEF_OFFSET_BITS;
  localparam int VPN_COUNT  = 1 << VPN_BITS;
  localparam int PHYS_DEPTH = DEF_FRAME_COUNT * PAGE_WORDS;

  typedef struct packed {
    logic        status;
    logic [31:0] read_data;
  } access_result_t;

  access_result_t expected_results[$];

  logic [31:0] phys_mem [PHYS_DEPTH];
  logic [31:0] swap_mem [int];

  // scan state
  int  highest_frame;
  bit  empty_hit;
  int  sel_frame, sel_parent, sel_slot;
  bit  victim_hit;
  int  victim_dist, victim_page;

  function automatic logic [31:0] swap_rd(int idx);
    if (swap_mem.exists(idx)) return swap_mem[idx];
    return '0;
  endfunction

  function automatic void scan_empty(int fr, int depth, int excl, int parent, int slot);
    bit          empty;
    logic [31:0] v;
    int          f;
    empty = 1;
    for (int s = 0; s < PAGE_WORDS; s++) begin
      v = phys_mem[fr * PAGE_WORDS + s];
      if (v != 0) begin
        f = v % DEF_FRAME_COUNT;
        empty = 0;
        if (f > highest_frame) highest_frame = f;
        if (depth + 1 < DEF_LEVELS) begin
          scan_empty(f, depth + 1, excl, fr, s);
          if (empty_hit) return;
        end
      end
    end
    if (empty && fr != 0 && fr != excl) begin
      empty_hit  = 1;
      sel_frame  = fr;
      sel_parent = parent;
      sel_slot   = slot;
    end
  endfunction

  function automatic int ring_dist(int a, int b);
    int d, w;
    d = a > b ? a - b : b - a;
    w = VPN_COUNT - d;
    return w < d ? w : d;
  endfunction

  function automatic void scan_victim(int fr, int depth, int prefix, int target);
    logic [31:0] v;
    int          pg, d;
    for (int s = 0; s < PAGE_WORDS; s++) begin
      v = phys_mem[fr * PAGE_WORDS + s];
      if (v != 0) begin
        pg = ((prefix << DEF_OFFSET_BITS) | s) & (VPN_COUNT - 1);
        if (depth + 1 < DEF_LEVELS) begin
          scan_victim(v % DEF_FRAME_COUNT, depth + 1, pg, target);
        end else begin
          d = ring_dist(target, pg);
          if (d > victim_dist) begin
            victim_hit  = 1;
            victim_dist = d;
            sel_frame   = v % DEF_FRAME_COUNT;
            sel_parent  = fr;
            sel_slot    = s;
            victim_page = pg;
          end
        end
      end
    end
  endfunction

  function automatic bit grab_frame(int vpn, int excl, output int nf);
    highest_frame = 0;
    empty_hit     = 0;
    scan_empty(0, 0, excl, 0, 0);
    if (empty_hit) begin
      phys_mem[sel_parent * PAGE_WORDS + sel_slot] = '0;
      nf = sel_frame;
      return 1;
    end
    if (highest_frame + 1 < DEF_FRAME_COUNT) begin
      nf = highest_frame + 1;
      return 1;
    end
    victim_hit  = 0;
    victim_dist = 0;
    scan_victim(0, 0, 0, vpn);
    if (!victim_hit) return 0;
    phys_mem[sel_parent * PAGE_WORDS + sel_slot] = '0;
    for (int j = 0; j < PAGE_WORDS; j++)
      swap_mem[victim_page * PAGE_WORDS + j] = phys_mem[sel_frame * PAGE_WORDS + j];
    nf = sel_frame;
    return 1;
  endfunction

  function automatic access_result_t walk_access(logic k, logic [23:0] va, logic [31:0] wd);
    access_result_t r;
    int             vpn, cur, idx, nf;
    logic [31:0]    v;
    r   = '0;
    cur = 0;
    if (va >= (1 << DEF_VADDR_BITS)) begin
      r.status = 1'b1;
      return r;
    end
    vpn = (va >> DEF_OFFSET_BITS) & (VPN_COUNT - 1);
    for (int lvl = 0; lvl < DEF_LEVELS; lvl++) begin
      idx = (va >> (DEF_OFFSET_BITS * (DEF_LEVELS - lvl))) & (PAGE_WORDS - 1);
      v   = phys_mem[cur * PAGE_WORDS + idx];
      if (v == 0) begin
        if (!grab_frame(vpn, cur, nf)) begin
          r.status = 1'b1;
          return r;
        end
        for (int j = 0; j < PAGE_WORDS; j++)
          phys_mem[nf * PAGE_WORDS + j] = (lvl + 1 < DEF_LEVELS) ? '0 :
                                          swap_rd(vpn * PAGE_WORDS + j);
        phys_mem[cur * PAGE_WORDS + idx] = nf;
        cur = nf;
      end else begin
        cur = v % DEF_FRAME_COUNT;
      end
    end
    idx = cur * PAGE_WORDS + (va & (PAGE_WORDS - 1));
    if (k) phys_mem[idx] = wd;
    else   r.read_data = phys_mem[idx];
    return r;
  endfunction

  initial begin
    for (int i = 0; i < PHYS_DEPTH; i++) phys_mem[i] = '0;
  end

  assign pending = expected_results.size();

  always @(posedge clk) begin
    access_result_t exp_r;
    if (rst) begin
      errors = 0;
    end else begin
      if (start && !busy)
        expected_results.push_back(walk_access(kind, virtual_address, write_data));
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d read_data=%h", $time, status, read_data);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
            errors++;
          end
          if (read_data !== exp_r.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, exp_r.read_data,
                     read_data);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ----- sim/hierarchical_page_table_walker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_page_table_walker_tb
// Drives reads and writes, in range and out of range, through the walker
// with random gaps; the checker predicts and compares every transaction.
// ----------------------------------------------------------------------------
module hierarchical_page_table_walker_tb;
  import hptw_pkg::*;

  localparam int WATCHDOG_LIMIT = 5_000_000;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic                    kind;
  logic [VA_PORT_BITS-1:0] virtual_address;
  logic signed [31:0]      write_data;
  logic                    done;
  logic                    status;
  logic signed [31:0]      read_data;
  int                      errors, pending;
  int                      idle_pct;
  int                      n_reads, n_writes, n_oor;
  int                      quiet_cycles;

  hierarchical_page_table_walker i_dut (
    .clk, .rst, .start, .busy, .kind, .virtual_address, .write_data,
    .done, .status, .read_data
  );

  hptw_checker i_checker (
    .clk, .rst, .start, .busy, .kind, .virtual_address, .write_data,
    .done, .status, .read_data, .errors, .pending
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic issue(logic k, logic [23:0] va, logic [31:0] wd);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start           <= 1;
    kind            <= k;
    virtual_address <= va;
    write_data      <= wd;
    do @(posedge clk); while (busy);
    if (va >= (1 << DEF_VADDR_BITS)) n_oor++;
    else if (k) n_writes++;
    else n_reads++;
  endtask

  function automatic logic [23:0] pick_address(int mode);
    case (mode)
      0: return 24'($urandom_range(0, 255));      // hot small region
      1: return 24'($urandom_range(0, (1 << DEF_VADDR_BITS) - 1));
      default: return 24'($urandom_range(1 << DEF_VADDR_BITS, (1 << VA_PORT_BITS) - 1));
    endcase
  endfunction

  initial begin
    int          r;
    logic [23:0] va;
    rst             = 1;
    start           = 0;
    kind            = 0;
    virtual_address = '0;
    write_data      = '0;
    idle_pct        = 0;
    n_reads = 0; n_writes = 0; n_oor = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    issue(1'b0, 24'h000000, 32'h0);
    issue(1'b1, 24'h000000, 32'h7FFFFFFF);
    issue(1'b0, 24'h000000, 32'h0);
    issue(1'b1, 24'h0FFFFF, 32'h80000000);
    issue(1'b0, 24'h0FFFFF, 32'h0);
    issue(1'b1, 24'h0FFFFE, 32'hFFFFFFFF);
    issue(1'b0, 24'h0FFFFE, 32'h0);
    issue(1'b0, 24'h100000, 32'h0);
    issue(1'b1, 24'hFFFFFF, 32'hFFFFFFFF);
    issue(1'b1, 24'h080000, 32'h5A5A5A5A);
    issue(1'b0, 24'h080000, 32'h0);
    issue(1'b0, 24'h012345, 32'h0);          // untouched page reads zero
    // many distinct top-level paths to take up frames
    for (int i = 0; i < 12; i++)
      issue(1'b1, 24'((i << 16) | (i << 12) | 4'hA), $urandom);
    issue(1'b0, 24'h000000, 32'h0);          // read back page zero after the writes above

    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 7 : (ph == 1) ? 75 : 0;
      for (int i = 0; i < 88; i++) begin
        r  = $urandom_range(99);
        va = pick_address(r < 50 ? 0 : r < 90 ? 1 : 2);
        issue(1'($urandom_range(1)), va, $urandom);
      end
      // hold off until the walker has drained
      start <= 0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d reads, %0d writes, %0d out-of-range accesses,", n_reads, n_writes,
             n_oor);
    $display("including frame reuse, eviction to swap and reload from swap.");
    if (errors == 0 && pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
